// ===== sv/usbep0_pkg.sv =====
// Package: shared types and codes of the control endpoint zero request engine.
`timescale 1ns / 1ps
package usbep0_pkg;

    // Control event codes
    localparam logic [1:0] OP_SETUP    = 2'd0;
    localparam logic [1:0] OP_IN_DONE  = 2'd1;
    localparam logic [1:0] OP_OUT_DONE = 2'd2;

    // Result action codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_STALL     = 3'd1;
    localparam logic [2:0] ACT_IN        = 3'd2;
    localparam logic [2:0] ACT_FWD_SETUP = 3'd3;
    localparam logic [2:0] ACT_FWD_OUT   = 3'd4;
    localparam logic [2:0] ACT_FWD_IN    = 3'd5;

    // Reply source codes
    localparam logic [1:0] SRC_ZERO    = 2'd0;
    localparam logic [1:0] SRC_CONFIG  = 2'd1;
    localparam logic [1:0] SRC_DESC    = 2'd2;
    localparam logic [1:0] SRC_PREFILL = 2'd3;

    // Standard request codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    // Request type bits that select class or vendor requests
    localparam logic [7:0] TYPE_KIND_MASK = 8'h60;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
        logic [15:0] descriptor_size;
        logic        descriptor_in_buffer;
        logic        config_accepted;
        logic        interface_accepted;
    } t_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] in_length;
        logic [15:0] in_offset;
        logic [1:0]  reply_source;
        logic [7:0]  reply_byte;
        logic        arm_status_out;
        logic        prefilled_flag;
        logic        address_valid;
        logic [6:0]  device_address;
        logic [7:0]  current_configuration;
    } t_result;

    typedef struct packed {
        logic [7:0]  saved_type;
        logic [7:0]  saved_code;
        logic [15:0] saved_value;
        logic [15:0] bytes_remaining;
        logic [15:0] send_offset;
        logic [7:0]  selected_configuration;
    } t_state;

endpackage

// ===== sv/usbep0_item_if.sv =====
// Interface: valid/ready channel that carries one control event word.
`timescale 1ns / 1ps
interface usbep0_item_if;
    logic                 valid;
    logic                 ready;
    usbep0_pkg::t_item    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/usbep0_result_if.sv =====
// Interface: valid/ready channel that carries one endpoint result word.
`timescale 1ns / 1ps
interface usbep0_result_if;
    logic                 valid;
    logic                 ready;
    usbep0_pkg::t_result  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/usbep0_in_reg.sv =====
// Input register stage: captures one event word and holds it until it moves on.
`timescale 1ns / 1ps
module usbep0_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    usbep0_item_if.sink           i_item,
    input  logic                  i_take,
    output logic                  o_valid,
    output usbep0_pkg::t_item     o_item
);

    logic              r_valid;
    usbep0_pkg::t_item r_item;
    logic              n_load;

    // Accept when empty or when the held word moves on this cycle
    assign i_item.ready = !r_valid || i_take;
    assign n_load       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_item <= i_item.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/usbep0_decode.sv =====
// Request decoder: result word and next state for one event word.
`timescale 1ns / 1ps
module usbep0_decode #(
    parameter int MAX_PACKET = 64
) (
    input  usbep0_pkg::t_item     i_item,
    input  usbep0_pkg::t_state    i_state,
    output usbep0_pkg::t_result   o_result,
    output usbep0_pkg::t_state    o_state
);

    localparam logic [15:0] MaxPkt = 16'(MAX_PACKET);

    logic        is_setup;
    logic        new_std;
    logic        saved_std;
    logic [15:0] clamped;
    logic [15:0] chunk_rem;
    logic [15:0] chunk_off;
    logic [15:0] chunk_len;

    assign is_setup  = (i_item.operation == usbep0_pkg::OP_SETUP);
    assign new_std   = (i_item.request_type & usbep0_pkg::TYPE_KIND_MASK) == 8'h00;
    assign saved_std = (i_state.saved_type & usbep0_pkg::TYPE_KIND_MASK) == 8'h00;

    // Clamp the descriptor size to the host's length
    assign clamped = (i_item.descriptor_size > i_item.request_length) ?
                     i_item.request_length : i_item.descriptor_size;

    // A chunk starts from the fresh clamp on setup, else from the saved transfer
    assign chunk_rem = is_setup ? clamped : i_state.bytes_remaining;
    assign chunk_off = is_setup ? 16'd0   : i_state.send_offset;
    assign chunk_len = (chunk_rem > MaxPkt) ? MaxPkt : chunk_rem;

    always_comb begin
        o_result = '0;
        o_state  = i_state;

        case (i_item.operation)
            usbep0_pkg::OP_SETUP: begin
                // Save the setup packet and drop any stale transfer
                o_state.saved_type      = i_item.request_type;
                o_state.saved_code      = i_item.request_code;
                o_state.saved_value     = i_item.request_value;
                o_state.bytes_remaining = 16'd0;
                o_state.send_offset     = 16'd0;
                if (!new_std) begin
                    o_result.action = usbep0_pkg::ACT_FWD_SETUP;
                end else begin
                    case (i_item.request_code)
                        usbep0_pkg::REQ_GET_STATUS: begin
                            o_result.action         = usbep0_pkg::ACT_IN;
                            o_result.in_length      = 16'd2;
                            o_result.reply_source   = usbep0_pkg::SRC_ZERO;
                            o_result.arm_status_out = 1'b1;
                        end
                        usbep0_pkg::REQ_CLEAR_FEATURE,
                        usbep0_pkg::REQ_SET_FEATURE,
                        usbep0_pkg::REQ_SET_ADDRESS: begin
                            o_result.action         = usbep0_pkg::ACT_IN;
                            o_result.reply_source   = usbep0_pkg::SRC_ZERO;
                            o_result.arm_status_out = 1'b1;
                        end
                        usbep0_pkg::REQ_GET_DESCRIPTOR: begin
                            if (i_item.descriptor_size == 16'd0) begin
                                o_result.action = usbep0_pkg::ACT_STALL;
                            end else if (i_item.descriptor_in_buffer) begin
                                o_result.action         = usbep0_pkg::ACT_IN;
                                o_result.in_length      = clamped;
                                o_result.reply_source   = usbep0_pkg::SRC_PREFILL;
                                o_result.prefilled_flag = 1'b1;
                            end else begin
                                o_result.action         = usbep0_pkg::ACT_IN;
                                o_result.in_length      = chunk_len;
                                o_result.in_offset      = chunk_off;
                                o_result.reply_source   = usbep0_pkg::SRC_DESC;
                                o_result.arm_status_out = (chunk_len == 16'd0);
                                o_state.bytes_remaining = chunk_rem - chunk_len;
                                o_state.send_offset     = chunk_off + chunk_len;
                            end
                        end
                        usbep0_pkg::REQ_GET_CONFIGURATION: begin
                            o_result.action         = usbep0_pkg::ACT_IN;
                            o_result.in_length      = 16'd1;
                            o_result.reply_source   = usbep0_pkg::SRC_CONFIG;
                            o_result.arm_status_out = 1'b1;
                            o_result.reply_byte     = i_state.selected_configuration;
                        end
                        usbep0_pkg::REQ_SET_CONFIGURATION: begin
                            if (i_item.config_accepted) begin
                                o_state.selected_configuration = i_item.request_value[7:0];
                                o_result.action         = usbep0_pkg::ACT_IN;
                                o_result.reply_source   = usbep0_pkg::SRC_ZERO;
                                o_result.arm_status_out = 1'b1;
                            end else begin
                                o_result.action = usbep0_pkg::ACT_STALL;
                            end
                        end
                        usbep0_pkg::REQ_SET_INTERFACE: begin
                            if (i_item.interface_accepted) begin
                                o_result.action         = usbep0_pkg::ACT_IN;
                                o_result.reply_source   = usbep0_pkg::SRC_ZERO;
                                o_result.arm_status_out = 1'b1;
                            end else begin
                                o_result.action = usbep0_pkg::ACT_STALL;
                            end
                        end
                        default: begin
                            o_result.action = usbep0_pkg::ACT_STALL;
                        end
                    endcase
                end
            end
            usbep0_pkg::OP_IN_DONE: begin
                // Forward a class IN complete, send the next chunk, or make the new address take effect
                if (!saved_std) begin
                    o_result.action = usbep0_pkg::ACT_FWD_IN;
                end else if (i_state.saved_code == usbep0_pkg::REQ_SET_ADDRESS) begin
                    o_result.address_valid  = 1'b1;
                    o_result.device_address = i_state.saved_value[6:0];
                end else if (i_state.saved_code == usbep0_pkg::REQ_GET_DESCRIPTOR) begin
                    o_result.action         = usbep0_pkg::ACT_IN;
                    o_result.in_length      = chunk_len;
                    o_result.in_offset      = chunk_off;
                    o_result.reply_source   = usbep0_pkg::SRC_DESC;
                    o_result.arm_status_out = (chunk_len == 16'd0);
                    o_state.bytes_remaining = chunk_rem - chunk_len;
                    o_state.send_offset     = chunk_off + chunk_len;
                end
            end
            usbep0_pkg::OP_OUT_DONE: begin
                if (!saved_std) begin
                    o_result.action = usbep0_pkg::ACT_FWD_OUT;
                end
            end
            default: begin
                // Unknown event: no action, state unchanged
            end
        endcase

        o_result.current_configuration = o_state.selected_configuration;
    end

endmodule

// ===== sv/usb_ep0_standard_request_engine.sv =====
// Top level: control endpoint zero standard request engine.
//
// Usage:
//   i_item carries control events (setup packet, IN complete, OUT complete)
//   together with the external descriptor lookup and acceptance answers.
//   o_result carries exactly one result word per event: the endpoint action,
//   IN length/offset/source, status-OUT arm, address update and the current
//   configuration.
//   An accepted word waits in the input register and is decoded into the
//   result register. Throughput: one word per cycle while the receiver takes
//   results; the decode is a single pass of compares and one 16-bit
//   subtract/add, and the saved request and transfer state update as each
//   word leaves the input register, so the following word sees it at once.
//   Reset (synchronous, active low) clears both pipeline registers and all
//   state: no configuration selected, no transfer pending.
//   When the receiver stalls, the result register holds, the input register
//   fills and then i_item.ready drops; no word is lost or repeated.
//   MAX_PACKET sets the largest descriptor chunk per IN packet (8 to 64).
`timescale 1ns / 1ps
module usb_ep0_standard_request_engine #(
    parameter int MAX_PACKET = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    usbep0_item_if.sink       i_item,
    usbep0_result_if.source   o_result
);

    logic                 s1_valid;
    usbep0_pkg::t_item    s1_item;
    logic                 s1_take;
    usbep0_pkg::t_result  dec_result;
    usbep0_pkg::t_state   dec_state;

    logic                 r_out_valid;
    usbep0_pkg::t_result  r_out;
    usbep0_pkg::t_state   r_state;
    logic                 out_free;

    // Result register frees when empty or taken this cycle
    assign out_free = !r_out_valid || o_result.ready;
    assign s1_take  = s1_valid && out_free;

    usbep0_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (out_free),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    usbep0_decode #(
        .MAX_PACKET (MAX_PACKET)
    ) u_decode (
        .i_item   (s1_item),
        .i_state  (r_state),
        .o_result (dec_result),
        .o_state  (dec_state)
    );

    // Advance saved state as each word is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_take) begin
            r_state <= dec_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_out <= dec_result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

// ===== tb/usb_ep0_standard_request_engine_tb.sv =====
// Testbench: self-checking random and directed run of the endpoint zero request engine.
`timescale 1ns / 1ps
module usb_ep0_standard_request_engine_tb;

    localparam int CHUNK_MAX      = 64;
    localparam int EVENT_TARGET   = 1750;
    localparam int CALM_TAIL      = 200;
    localparam int CYCLE_LIMIT    = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Track selected configuration, saved setup and descriptor transfer; predict each response
    class ep0_response_tracker;
        usbep0_pkg::t_state  regs;
        usbep0_pkg::t_result expected_responses[$];
        int                  mismatch_count;

        function new();
            regs = '0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function bit is_standard(logic [7:0] kind);
            return (kind & usbep0_pkg::TYPE_KIND_MASK) == 8'h00;
        endfunction

        // Send the next descriptor chunk, at most one max packet
        function void next_chunk(ref usbep0_pkg::t_result r);
            logic [15:0] chunk;
            chunk = (regs.bytes_remaining > CHUNK_MAX) ? 16'(CHUNK_MAX) : regs.bytes_remaining;
            r.action         = usbep0_pkg::ACT_IN;
            r.in_length      = chunk;
            r.in_offset      = regs.send_offset;
            r.reply_source   = usbep0_pkg::SRC_DESC;
            r.arm_status_out = (chunk == 16'd0);
            regs.bytes_remaining = regs.bytes_remaining - chunk;
            regs.send_offset     = regs.send_offset + chunk;
        endfunction

        function void start_reply(ref usbep0_pkg::t_result r, input logic [15:0] len,
                                  input logic [1:0] src, input logic arm);
            r.action         = usbep0_pkg::ACT_IN;
            r.in_length      = len;
            r.reply_source   = src;
            r.arm_status_out = arm;
        endfunction

        function usbep0_pkg::t_result decide_response(usbep0_pkg::t_item it);
            usbep0_pkg::t_result r;
            logic [15:0]         clamped;
            r = '0;
            case (it.operation)
                usbep0_pkg::OP_SETUP: begin
                    regs.saved_type      = it.request_type;
                    regs.saved_code      = it.request_code;
                    regs.saved_value     = it.request_value;
                    regs.bytes_remaining = '0;
                    regs.send_offset     = '0;
                    if (!is_standard(it.request_type)) begin
                        r.action = usbep0_pkg::ACT_FWD_SETUP;
                    end else begin
                        case (it.request_code)
                            usbep0_pkg::REQ_GET_STATUS:
                                start_reply(r, 16'd2, usbep0_pkg::SRC_ZERO, 1'b1);
                            usbep0_pkg::REQ_CLEAR_FEATURE, usbep0_pkg::REQ_SET_FEATURE,
                            usbep0_pkg::REQ_SET_ADDRESS:
                                start_reply(r, 16'd0, usbep0_pkg::SRC_ZERO, 1'b1);
                            usbep0_pkg::REQ_GET_DESCRIPTOR: begin
                                if (it.descriptor_size == 16'd0) begin
                                    r.action = usbep0_pkg::ACT_STALL;
                                end else begin
                                    clamped = (it.descriptor_size > it.request_length) ?
                                              it.request_length : it.descriptor_size;
                                    if (it.descriptor_in_buffer) begin
                                        start_reply(r, clamped, usbep0_pkg::SRC_PREFILL, 1'b0);
                                        r.prefilled_flag = 1'b1;
                                    end else begin
                                        regs.bytes_remaining = clamped;
                                        next_chunk(r);
                                    end
                                end
                            end
                            usbep0_pkg::REQ_GET_CONFIGURATION: begin
                                start_reply(r, 16'd1, usbep0_pkg::SRC_CONFIG, 1'b1);
                                r.reply_byte = regs.selected_configuration;
                            end
                            usbep0_pkg::REQ_SET_CONFIGURATION: begin
                                if (it.config_accepted) begin
                                    regs.selected_configuration = it.request_value[7:0];
                                    start_reply(r, 16'd0, usbep0_pkg::SRC_ZERO, 1'b1);
                                end else begin
                                    r.action = usbep0_pkg::ACT_STALL;
                                end
                            end
                            usbep0_pkg::REQ_SET_INTERFACE: begin
                                if (it.interface_accepted) begin
                                    start_reply(r, 16'd0, usbep0_pkg::SRC_ZERO, 1'b1);
                                end else begin
                                    r.action = usbep0_pkg::ACT_STALL;
                                end
                            end
                            default: r.action = usbep0_pkg::ACT_STALL;
                        endcase
                    end
                end
                usbep0_pkg::OP_IN_DONE: begin
                    if (!is_standard(regs.saved_type)) begin
                        r.action = usbep0_pkg::ACT_FWD_IN;
                    end else if (regs.saved_code == usbep0_pkg::REQ_SET_ADDRESS) begin
                        r.address_valid  = 1'b1;
                        r.device_address = regs.saved_value[6:0];
                    end else if (regs.saved_code == usbep0_pkg::REQ_GET_DESCRIPTOR) begin
                        next_chunk(r);
                    end
                end
                usbep0_pkg::OP_OUT_DONE: begin
                    if (!is_standard(regs.saved_type)) r.action = usbep0_pkg::ACT_FWD_OUT;
                end
                default: ;
            endcase
            r.current_configuration = regs.selected_configuration;
            return r;
        endfunction

        function void note_event(usbep0_pkg::t_item it);
            expected_responses.push_back(decide_response(it));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_response(usbep0_pkg::t_result got);
            usbep0_pkg::t_result want;
            if (expected_responses.size() == 0) begin
                $error("response with no event pending: action 0x%0h", got.action);
                mismatch_count++;
                return;
            end
            want = expected_responses.pop_front();
            compare_field("action", 16'(want.action), 16'(got.action));
            compare_field("in_length", want.in_length, got.in_length);
            compare_field("in_offset", want.in_offset, got.in_offset);
            compare_field("reply_source", 16'(want.reply_source), 16'(got.reply_source));
            compare_field("reply_byte", 16'(want.reply_byte), 16'(got.reply_byte));
            compare_field("arm_status_out", 16'(want.arm_status_out),
                          16'(got.arm_status_out));
            compare_field("prefilled_flag", 16'(want.prefilled_flag),
                          16'(got.prefilled_flag));
            compare_field("address_valid", 16'(want.address_valid), 16'(got.address_valid));
            compare_field("device_address", 16'(want.device_address),
                          16'(got.device_address));
            compare_field("current_configuration", 16'(want.current_configuration),
                          16'(got.current_configuration));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idling_on;
    int   events_sent;
    int   cycle_count;
    int   stall_left;

    usbep0_item_if   item_if();
    usbep0_result_if res_if();

    ep0_response_tracker tracker;

    usb_ep0_standard_request_engine #(
        .MAX_PACKET(CHUNK_MAX)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(res_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Drop ready in random bursts while idling is on
    always @(negedge i_clk) begin
        if (!idling_on) begin
            res_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 16);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Check every accepted response word
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) tracker.check_response(res_if.payload);
    end

    function automatic usbep0_pkg::t_item random_event(logic [1:0] op);
        usbep0_pkg::t_item it;
        logic [127:0]      bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        it = bits[$bits(usbep0_pkg::t_item)-1:0];
        it.operation = op;
        return it;
    endfunction

    function automatic usbep0_pkg::t_item setup_event(logic [7:0] kind, logic [7:0] code,
                                                      logic [15:0] value, logic [15:0] len,
                                                      logic [15:0] size, logic in_buf,
                                                      logic cfg_ok, logic if_ok);
        usbep0_pkg::t_item it;
        it = random_event(usbep0_pkg::OP_SETUP);
        it.request_type         = kind;
        it.request_code         = code;
        it.request_value        = value;
        it.request_length       = len;
        it.descriptor_size      = size;
        it.descriptor_in_buffer = in_buf;
        it.config_accepted      = cfg_ok;
        it.interface_accepted   = if_ok;
        return it;
    endfunction

    // Present one word, hold it until accepted, then note it
    task automatic push_event(input usbep0_pkg::t_item it);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge i_clk); while (!item_if.ready);
        tracker.note_event(it);
        if (it.operation != OP_UNUSED) events_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_done(input logic [1:0] op);
        push_event(random_event(op));
    endtask

    // Hold off the sender until every response is back
    task automatic drain_responses();
        item_if.valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'($urandom);
        return 16'($urandom_range(1, 200));
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'($urandom);
        if (r == 2) return 16'd0;
        return 16'($urandom_range(1, 255));
    endfunction

    task automatic directed_events();
        // Completes straight after reset, before any setup
        push_done(usbep0_pkg::OP_OUT_DONE);
        push_done(usbep0_pkg::OP_IN_DONE);
        push_event(setup_event(8'h80, usbep0_pkg::REQ_GET_STATUS, 16'h0000, 16'h0002,
                               16'd0, 1'b0, 1'b0, 1'b0));
        push_event(setup_event(8'h00, usbep0_pkg::REQ_CLEAR_FEATURE, 16'h0001, 16'h0000,
                               16'd0, 1'b0, 1'b0, 1'b0));
        push_event(setup_event(8'h02, usbep0_pkg::REQ_SET_FEATURE, 16'h0000, 16'h0000,
                               16'd0, 1'b0, 1'b0, 1'b0));
        // Address takes effect on the IN complete
        push_event(setup_event(8'h00, usbep0_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'h0000,
                               16'd0, 1'b0, 1'b0, 1'b0));
        push_done(usbep0_pkg::OP_IN_DONE);
        // Absent descriptor stalls
        push_event(setup_event(8'h80, usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'h0012,
                               16'd0, 1'b0, 1'b0, 1'b0));
        // Largest descriptor clamped to the host length, sent in chunks then ZLPs
        push_event(setup_event(8'h80, usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0200, 16'd130,
                               16'hFFFF, 1'b0, 1'b0, 1'b0));
        repeat (4) push_done(usbep0_pkg::OP_IN_DONE);
        // Prefilled descriptor starts at once
        push_event(setup_event(8'h80, usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'hFFFF,
                               16'd18, 1'b1, 1'b0, 1'b0));
        push_done(usbep0_pkg::OP_IN_DONE);
        // Exactly one max packet, then a zero length packet
        push_event(setup_event(8'h80, usbep0_pkg::REQ_GET_DESCRIPTOR, 16'h0300, 16'd64,
                               16'd64, 1'b0, 1'b0, 1'b0));
        push_done(usbep0_pkg::OP_IN_DONE);
        push_event(setup_event(8'h00, usbep0_pkg::REQ_SET_CONFIGURATION, 16'h00FF, 16'h0000,
                               16'd0, 1'b0, 1'b1, 1'b0));
        push_event(setup_event(8'h80, usbep0_pkg::REQ_GET_CONFIGURATION, 16'h0000, 16'h0001,
                               16'd0, 1'b0, 1'b0, 1'b0));
        push_event(setup_event(8'h00, usbep0_pkg::REQ_SET_CONFIGURATION, 16'h0002, 16'h0000,
                               16'd0, 1'b0, 1'b0, 1'b1));
        push_event(setup_event(8'h01, usbep0_pkg::REQ_SET_INTERFACE, 16'h0001, 16'h0000,
                               16'd0, 1'b0, 1'b0, 1'b1));
        push_event(setup_event(8'h01, usbep0_pkg::REQ_SET_INTERFACE, 16'h0001, 16'h0000,
                               16'd0, 1'b0, 1'b1, 1'b0));
        // Unknown standard request stalls
        push_event(setup_event(8'h9F, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        // Class request and its completes go to the class
        push_event(setup_event(8'hFF, usbep0_pkg::REQ_GET_STATUS, 16'h0000, 16'h0000,
                               16'd0, 1'b0, 1'b0, 1'b0));
        push_done(usbep0_pkg::OP_IN_DONE);
        push_done(usbep0_pkg::OP_OUT_DONE);
        push_done(OP_UNUSED);
    endtask

    // Mostly well-formed control transfers with random content, some noise
    task automatic random_transfers();
        int          kind;
        int          n;
        bit          drained;
        logic [7:0]  std_type;
        logic [7:0]  cls_type;
        logic [15:0] size;
        logic [15:0] len;
        logic [15:0] clamped;
        logic [7:0]  other_codes[5];
        other_codes = '{usbep0_pkg::REQ_GET_STATUS, usbep0_pkg::REQ_CLEAR_FEATURE,
                        usbep0_pkg::REQ_SET_FEATURE, usbep0_pkg::REQ_SET_INTERFACE,
                        usbep0_pkg::REQ_GET_CONFIGURATION};
        drained = 0;
        while (events_sent < EVENT_TARGET) begin
            if (events_sent >= EVENT_TARGET - CALM_TAIL) idling_on = 0;
            if (!drained && events_sent >= EVENT_TARGET / 2) begin
                drain_responses();
                drained = 1;
            end
            kind     = $urandom_range(0, 99);
            std_type = 8'($urandom) & 8'h9F;
            cls_type = 8'($urandom);
            cls_type[6:5] = 2'($urandom_range(1, 3));
            if (kind < 35) begin
                size    = pick_size();
                len     = pick_length();
                clamped = (size > len) ? len : size;
                push_event(setup_event(std_type, usbep0_pkg::REQ_GET_DESCRIPTOR,
                                       16'($urandom), len, size,
                                       $urandom_range(0, 3) == 0, 1'($urandom),
                                       1'($urandom)));
                n = (clamped >> 6) + $urandom_range(1, 2);
                if (n > 10) n = $urandom_range(3, 10);
                repeat (n) push_done(usbep0_pkg::OP_IN_DONE);
                if ($urandom_range(0, 1)) push_done(usbep0_pkg::OP_OUT_DONE);
            end else if (kind < 50) begin
                push_event(setup_event(std_type, usbep0_pkg::REQ_SET_ADDRESS, 16'($urandom),
                                       16'($urandom), 16'($urandom), 1'($urandom),
                                       1'($urandom), 1'($urandom)));
                push_done(usbep0_pkg::OP_IN_DONE);
                if ($urandom_range(0, 2) == 0) push_done(usbep0_pkg::OP_IN_DONE);
            end else if (kind < 60) begin
                push_event(setup_event(std_type, usbep0_pkg::REQ_SET_CONFIGURATION,
                                       ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                                       16'($urandom), 16'($urandom), 1'($urandom),
                                       $urandom_range(0, 3) != 0, 1'($urandom)));
                push_event(setup_event(std_type | 8'h80, usbep0_pkg::REQ_GET_CONFIGURATION,
                                       16'($urandom), 16'd1, 16'($urandom), 1'($urandom),
                                       1'($urandom), 1'($urandom)));
                push_done(usbep0_pkg::OP_IN_DONE);
                push_done(usbep0_pkg::OP_OUT_DONE);
            end else if (kind < 70) begin
                push_event(setup_event(std_type, other_codes[$urandom_range(0, 4)],
                                       16'($urandom), 16'($urandom), 16'($urandom),
                                       1'($urandom), 1'($urandom), 1'($urandom)));
                push_done(usbep0_pkg::OP_OUT_DONE);
            end else if (kind < 82) begin
                push_event(setup_event(cls_type, 8'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), 1'($urandom), 1'($urandom),
                                       1'($urandom)));
                n = $urandom_range(0, 3);
                repeat (n) push_done($urandom_range(0, 1) ? usbep0_pkg::OP_IN_DONE
                                                          : usbep0_pkg::OP_OUT_DONE);
            end else if (kind < 92) begin
                push_event(setup_event(std_type, 8'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), 1'($urandom), 1'($urandom),
                                       1'($urandom)));
                push_done($urandom_range(0, 1) ? usbep0_pkg::OP_IN_DONE
                                               : usbep0_pkg::OP_OUT_DONE);
            end else begin
                push_event(random_event(2'($urandom_range(0, 3))));
            end
        end
    endtask

    initial begin
        tracker         = new();
        idling_on       = 1;
        events_sent     = 0;
        stall_left      = 0;
        i_rst_n         = 1'b0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        res_if.ready    = 1'b0;

        // Hold reset, release at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_events();
        drain_responses();
        random_transfers();

        // Wait for the last responses, then let the pipeline settle
        item_if.valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
